FILE: rtl/grtl_pkg.sv
`default_nettype none

package grtl_pkg;

    // Offset memory: fixed at 4096 entries, so index wrap is a plain mask
    localparam int GLYPH_AW    = 12;
    localparam int GLYPH_DEPTH = 1 << GLYPH_AW;

    localparam int CODE_W   = 16;
    localparam int COUNT_W  = 13;
    localparam int SLOT_W   = 12;
    localparam int OFFSET_W = 32;
    localparam int ADDR_W   = 32;
    localparam int RCOUNT_W = 7;
    localparam int CFG_DW   = 32;

    localparam logic [1:0] FUNC_RANGE  = 2'd0;
    localparam logic [1:0] FUNC_OFFSET = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    localparam logic CFG_RANGE_COUNT = 1'b0;
    localparam logic CFG_STREAM_BASE = 1'b1;

    typedef struct packed {
        logic [1:0]          func;
        logic [SLOT_W-1:0]   slot;
        logic [CODE_W-1:0]   code;
        logic [COUNT_W-1:0]  glyph_count;
        logic [GLYPH_AW-1:0] offset_base;
        logic [OFFSET_W-1:0] glyph_offset;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] glyph_address;
        logic              found;
    } t_out_item;

    typedef struct packed {
        logic [CODE_W-1:0]   start_code;
        logic [COUNT_W-1:0]  glyph_count;
        logic [GLYPH_AW-1:0] offset_base;
    } t_range_entry;

endpackage

`default_nettype wire

FILE: rtl/glyph_range_table_lookup.sv
// Range and offset writes give no result.
// A lookup doing p range probes (p <= ceil(log2(n+1)), n ranges in use) passes through S_CMP for
// each probe, S_OFF on a hit, then S_DONE and the output register; one item is in flight at a time.
// 64 ranges take at most 7 probes.
// Reset (i_rst_n low, synchronous) clears control, range_count and stream_base;
// range and offset memories keep their contents and must be written before use.
`default_nettype none

module glyph_range_table_lookup #(
    parameter int MAX_RANGES = 64
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire                               i_cfg_index,
    input  wire  [grtl_pkg::CFG_DW-1:0]       i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  grtl_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output grtl_pkg::t_out_item               o_out_item
);
    import grtl_pkg::*;

    localparam int RAW  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int NMAX = (MAX_RANGES < 127) ? MAX_RANGES : 127;
    localparam int CW   = $clog2(NMAX + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_OFF  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [RCOUNT_W-1:0] r_range_count;
    logic [ADDR_W-1:0]   r_stream_base;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi1, n_hi1;
    logic [CW-1:0]       r_mid, n_mid;
    t_out_item           r_res, n_res;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic                in_acc;
    logic                range_we;
    logic                offset_we;
    logic [RCOUNT_W-1:0] n_sat;
    logic [CW-1:0]       n_cnt;
    logic [CW-1:0]       mid0;
    t_range_entry        range_wdata;
    t_range_entry        range_rdata;
    logic [RAW-1:0]      range_raddr;
    logic [OFFSET_W-1:0] off_rdata;
    logic [GLYPH_AW-1:0] off_raddr;
    logic [CODE_W:0]     range_end;
    logic [CODE_W-1:0]   code_diff;
    logic                code_lt;
    logic                code_ge;
    logic                out_free;

    function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] lo,
                                             input logic [CW-1:0] hi1);
        logic [CW:0] s;
        s = {1'b0, lo} + {1'b0, hi1} - {{CW{1'b0}}, 1'b1};
        return s[CW:1];
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Saturate the range count at the table depth, capped at 127
    assign n_sat = (r_range_count > RCOUNT_W'(NMAX)) ? RCOUNT_W'(NMAX) : r_range_count;
    assign n_cnt = CW'(n_sat);
    assign mid0  = mid_of({CW{1'b0}}, n_cnt);

    always_comb begin
        range_we  = 1'b0;
        offset_we = 1'b0;
        if (in_acc) begin
            unique case (i_in_item.func)
                FUNC_RANGE: begin
                    range_we = ({1'b0, i_in_item.slot} < (SLOT_W + 1)'(MAX_RANGES));
                end
                FUNC_OFFSET: begin
                    offset_we = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign range_wdata.start_code  = i_in_item.code;
    assign range_wdata.glyph_count = i_in_item.glyph_count;
    assign range_wdata.offset_base = i_in_item.offset_base;

    // Compare against the entry read for the current probe
    assign range_end = {1'b0, range_rdata.start_code} + {4'b0, range_rdata.glyph_count};
    assign code_lt   = (r_code < range_rdata.start_code);
    assign code_ge   = ({1'b0, r_code} >= range_end);
    assign code_diff = r_code - range_rdata.start_code;
    assign off_raddr = range_rdata.offset_base + code_diff[GLYPH_AW-1:0];

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_lo    = r_lo;
        n_hi1   = r_hi1;
        n_mid   = r_mid;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_item.func == FUNC_LOOKUP)) begin
                    n_code = i_in_item.code;
                    n_lo   = '0;
                    n_hi1  = n_cnt;
                    n_mid  = mid0;
                    n_res.glyph_address = r_stream_base;
                    n_res.found         = 1'b0;
                    n_state = (n_cnt == '0) ? S_DONE : S_CMP;
                end
            end
            S_CMP: begin
                if (!code_lt && !code_ge) begin
                    n_state = S_OFF;
                end else begin
                    if (code_lt) begin
                        n_hi1 = r_mid;
                    end else begin
                        n_lo = r_mid + {{(CW-1){1'b0}}, 1'b1};
                    end
                    n_mid = mid_of(n_lo, n_hi1);
                    if (n_lo >= n_hi1) begin
                        n_res.glyph_address = r_stream_base;
                        n_res.found         = 1'b0;
                        n_state             = S_DONE;
                    end
                end
            end
            S_OFF: begin
                n_res.glyph_address = r_stream_base + off_rdata;
                n_res.found         = 1'b1;
                n_state             = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Probe address: first midpoint at accept, next midpoint while searching
    assign range_raddr = RAW'((r_state == S_IDLE) ? mid0 : n_mid);

    grtl_range_ram #(
        .DEPTH (MAX_RANGES),
        .AW    (RAW)
    ) u_range_ram (
        .i_clk   (i_clk),
        .i_we    (range_we),
        .i_waddr (i_in_item.slot[RAW-1:0]),
        .i_wdata (range_wdata),
        .i_raddr (range_raddr),
        .o_rdata (range_rdata)
    );

    grtl_offset_ram u_offset_ram (
        .i_clk   (i_clk),
        .i_we    (offset_we),
        .i_waddr (i_in_item.slot[GLYPH_AW-1:0]),
        .i_wdata (i_in_item.glyph_offset),
        .i_raddr (off_raddr),
        .o_rdata (off_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_range_count <= '0;
            r_stream_base <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RANGE_COUNT: r_range_count <= i_cfg_data[RCOUNT_W-1:0];
                    CFG_STREAM_BASE: r_stream_base <= i_cfg_data[ADDR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_lo   <= n_lo;
        r_hi1  <= n_hi1;
        r_mid  <= n_mid;
        r_res  <= n_res;
        if ((r_state == S_DONE) && out_free) begin
            r_out_item <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_lo < r_hi1) && (r_mid >= r_lo) && (r_mid < r_hi1))
        else $error("search window empty or probe outside it");

    a_off_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OFF) |-> ($past(r_state) == S_CMP))
        else $error("offset read without a range hit");

    a_empty_table_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_item.func == FUNC_LOOKUP) && (n_cnt == '0))
        |=> (r_state == S_DONE) && !r_res.found)
        else $error("lookup on empty table did not miss");

    a_done_only_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result shown without a finished lookup");
`endif

endmodule

`default_nettype wire

FILE: rtl/grtl_range_ram.sv
`default_nettype none

module grtl_range_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire                        i_clk,
    input  wire                        i_we,
    input  wire  [AW-1:0]              i_waddr,
    input  grtl_pkg::t_range_entry     i_wdata,
    input  wire  [AW-1:0]              i_raddr,
    output grtl_pkg::t_range_entry     o_rdata
);
    import grtl_pkg::*;

    t_range_entry r_mem [DEPTH];
    t_range_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/grtl_offset_ram.sv
`default_nettype none

module grtl_offset_ram (
    input  wire                              i_clk,
    input  wire                              i_we,
    input  wire  [grtl_pkg::GLYPH_AW-1:0]    i_waddr,
    input  wire  [grtl_pkg::OFFSET_W-1:0]    i_wdata,
    input  wire  [grtl_pkg::GLYPH_AW-1:0]    i_raddr,
    output logic [grtl_pkg::OFFSET_W-1:0]    o_rdata
);
    import grtl_pkg::*;

    logic [OFFSET_W-1:0] r_mem [GLYPH_DEPTH];
    logic [OFFSET_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
